@@ sv/rfrs_pkg.sv @@
// ----------------------------------------------------------------------------
// rfrs_pkg
// Shared types, codes and widths of the ring FIFO with rewind and snapshot.
// ----------------------------------------------------------------------------
package rfrs_pkg;

  // Default parameter values
  localparam int DEPTH_DEF     = 256;
  localparam int ELEM_BITS_DEF = 32;
  localparam int MAX_RUN_DEF   = 64;

  // Fixed field widths
  localparam int SIZE_W   = 9;    // size in use, counts, unread amount
  localparam int VALUE_W  = 32;   // push and pop element field
  localparam int REQ_W    = 7;    // pop run request
  localparam int OP_W     = 3;
  localparam int STAT_W   = 3;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // Size in use after reset, before the clamp to the storage depth
  localparam int SIZE_RESET = 256;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_UNREAD  = 3'd2,
    OP_SAVE    = 3'd3,
    OP_RESTORE = 3'd4,
    OP_FLUSH   = 3'd5,
    OP_SET_EN  = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_PUSH_DIS    = 3'd3,
    ST_POP_DIS     = 3'd4,
    ST_UNREAD_BIG  = 3'd5
  } status_e;

  // Memory port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } memctl_t;

  // Free space: size minus count, zero when the count reaches the size
  function automatic logic [SIZE_W-1:0] free_slots(input logic [SIZE_W-1:0] cnt,
                                                   input logic [SIZE_W-1:0] size);
    free_slots = (size > cnt) ? (size - cnt) : '0;
  endfunction

endpackage

@@ sv/rfrs_store.sv @@
// ----------------------------------------------------------------------------
// rfrs_store
// Element storage: one write and one registered read port, with a clearing
// sweep after reset that zeroes every entry, one per cycle.
// ----------------------------------------------------------------------------
module rfrs_store import rfrs_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  memctl_t              ctl_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [ELEM_BITS-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [ELEM_BITS-1:0] rdata_o,
  output logic                 clr_busy_o
);

  logic [ELEM_BITS-1:0] mem [DEPTH];
  logic [ELEM_BITS-1:0] rdata_q;
  logic                 clr_busy_q, clr_busy_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;

  // Advance the clearing sweep until the last entry is zeroed
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Write port shared by the sweep and element writes; read data registered
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

@@ sv/ring_fifo_rewind_snapshot.sv @@
// ----------------------------------------------------------------------------
// ring_fifo_rewind_snapshot
// Circular FIFO over a programmable size, with pop runs, unread (rewind) and
// one saved snapshot of both pointers and the count.
// ----------------------------------------------------------------------------
// Usage:
//   Command items enter on s_axis (operation in tuser, operands in tdata).
//   Results leave on m_axis: one per command, or one per element for a pop
//   run, with tlast on the final result of each command.
//   The size in use is written on the cfg channel; the user must write it
//   only while the block idles, and the block itself does not enforce it.
// Timing:
//   A command other than a successful pop run gives its result in the output
//   register in the cycle after acceptance; one such command per cycle while
//   m_axis_tready is high. A pop run blocks the input until its last element
//   has left the memory read register; its elements pass that register and
//   then the output register, one element a cycle while m_axis_tready is high.
// Reset:
//   Pointers, count, snapshot clear, both enables set, size in use 256
//   (clamped to DEPTH). A sweep then zeroes the memory; s_axis_tready stays
//   low until the cycle after it ends. cfg writes are taken throughout.
// Stall:
//   When m_axis_tready is low and a result waits in the output register, it
//   holds there, the pop run pauses and no new command is accepted.
module ring_fifo_rewind_snapshot import rfrs_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int MAX_RUN   = MAX_RUN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Size in use write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SIZE_W-1:0]      cfg_data_i,
  // Command items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: push_value[31:0], pop_request[38:32], unread_amount[47:39],
  //        allow_push[48], allow_pop[49], zero[55:50]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: operation[2:0]
  input  logic [OP_W-1:0]        s_axis_tuser,
  // Result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: status[2:0], popped_value[34:3], stored_count[43:35],
  //        free_count[52:44], zero[55:53]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: value_valid
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam int VW   = (ELEM_BITS < VALUE_W) ? ELEM_BITS : VALUE_W;
  localparam logic [SIZE_W-1:0] SizeRst =
    SIZE_W'((DEPTH < SIZE_RESET) ? DEPTH : SIZE_RESET);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_POP   = 3'b100
  } state_e;

  // Input fields
  logic [VALUE_W-1:0] push_value;
  logic [REQ_W-1:0]   pop_request;
  logic [SIZE_W-1:0]  unread_amount;
  logic               allow_push, allow_pop;

  assign push_value    = s_axis_tdata[31:0];
  assign pop_request   = s_axis_tdata[38:32];
  assign unread_amount = s_axis_tdata[47:39];
  assign allow_push    = s_axis_tdata[48];
  assign allow_pop     = s_axis_tdata[49];

  // Control state
  state_e            state_q, state_d;
  logic [AW-1:0]     rd_q, rd_d, wr_q, wr_d, srd_q, srd_d, swr_q, swr_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d, scnt_q, scnt_d, size_q, size_d;
  logic              push_en_q, push_en_d, pop_en_q, pop_en_d;
  logic [REQ_W-1:0]  rem_q, rem_d;

  // Element waiting in the memory read register, and the output register
  logic              pend_q, pend_d;
  logic [SIZE_W-1:0] pend_cnt_q, pend_free_q;
  logic              pend_last_q;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [VALUE_W-1:0] out_value_q;
  logic              out_vvalid_q, out_last_q;
  logic [SIZE_W-1:0] out_cnt_q, out_free_q;

  // Memory
  memctl_t            memctl;
  logic [ELEM_BITS-1:0] rdata;
  logic                 clr_busy;

  logic    in_acc, pend_move, pop_issue, res_load;
  status_e res_status;
  logic [CMPW-1:0] rd_inc, wr_inc;
  logic [AW-1:0]   rd_adv, wr_adv;
  logic [REQ_W-1:0] want_run, want;
  logic [SIZE_W-1:0] free_now;

  rfrs_store #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (memctl),
    .waddr_i    (wr_q),
    .wdata_i    (ELEM_BITS'(push_value[VW-1:0])),
    .raddr_i    (rd_q),
    .rdata_o    (rdata),
    .clr_busy_o (clr_busy)
  );

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign pend_move     = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == S_IDLE) && !pend_q && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pop_issue     = (state_q == S_POP) && (!pend_q || pend_move);

  // Pointer advance with wrap at the size in use
  assign rd_inc = CMPW'(rd_q) + 1'b1;
  assign wr_inc = CMPW'(wr_q) + 1'b1;
  assign rd_adv = (rd_inc >= CMPW'(size_q)) ? '0 : rd_inc[AW-1:0];
  assign wr_adv = (wr_inc >= CMPW'(size_q)) ? '0 : wr_inc[AW-1:0];

  // Clamp the run to MAX_RUN and then to the count
  assign want_run = (pop_request > REQ_W'(MAX_RUN)) ? REQ_W'(MAX_RUN) : pop_request;
  assign want     = (SIZE_W'(want_run) > cnt_q) ? cnt_q[REQ_W-1:0] : want_run;
  assign free_now = free_slots(cnt_q, size_q);

  // Clamp the written size to 1..DEPTH
  always_comb begin
    size_d = size_q;
    if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        size_d = SIZE_W'(1);
      end else if (CMPW'(cfg_data_i) > CMPW'(DEPTH)) begin
        size_d = SIZE_W'(DEPTH);
      end else begin
        size_d = cfg_data_i;
      end
    end
  end

  // Decode commands and sequence pop runs
  always_comb begin
    state_d    = state_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    cnt_d      = cnt_q;
    srd_d      = srd_q;
    swr_d      = swr_q;
    scnt_d     = scnt_q;
    push_en_d  = push_en_q;
    pop_en_d   = pop_en_q;
    rem_d      = rem_q;
    res_status = ST_OK;
    res_load   = 1'b0;
    memctl     = '0;
    case (state_q)
      S_CLEAR: begin
        if (!clr_busy) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_load = 1'b1;
          case (op_e'(s_axis_tuser))
            OP_PUSH: begin
              if (!push_en_q) begin
                res_status = ST_PUSH_DIS;
              end else if (cnt_q >= size_q) begin
                res_status = ST_FULL;
              end else begin
                memctl.wr_en = 1'b1;
                wr_d  = wr_adv;
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_POP: begin
              if (!pop_en_q) begin
                res_status = ST_POP_DIS;
              end else if (cnt_q == '0) begin
                res_status = ST_EMPTY;
              end else if (want != '0) begin
                res_load = 1'b0;
                rem_d    = want;
                state_d  = S_POP;
              end
            end
            OP_UNREAD: begin
              if (unread_amount > free_now) begin
                res_status = ST_UNREAD_BIG;
              end else begin
                cnt_d     = cnt_q + unread_amount;
                push_en_d = 1'b1;
                if (CMPW'(rd_q) >= CMPW'(unread_amount)) begin
                  rd_d = AW'(CMPW'(rd_q) - CMPW'(unread_amount));
                end else begin
                  rd_d = AW'(CMPW'(rd_q) + CMPW'(size_q) - CMPW'(unread_amount));
                end
              end
            end
            OP_SAVE: begin
              srd_d  = rd_q;
              swr_d  = wr_q;
              scnt_d = cnt_q;
            end
            OP_RESTORE: begin
              rd_d  = srd_q;
              wr_d  = swr_q;
              cnt_d = scnt_q;
            end
            OP_FLUSH: begin
              rd_d      = '0;
              wr_d      = '0;
              cnt_d     = '0;
              push_en_d = 1'b1;
              pop_en_d  = 1'b1;
            end
            OP_SET_EN: begin
              push_en_d = allow_push;
              pop_en_d  = allow_pop;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (pop_issue) begin
          memctl.rd_en = 1'b1;
          rd_d  = rd_adv;
          cnt_d = cnt_q - 1'b1;
          rem_d = rem_q - 1'b1;
          if (rem_q == REQ_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Track the element in the read register and the output register
  always_comb begin
    pend_d = pend_q;
    if (pop_issue) begin
      pend_d = 1'b1;
    end else if (pend_move) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (res_load || pend_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rd_q        <= '0;
      wr_q        <= '0;
      cnt_q       <= '0;
      srd_q       <= '0;
      swr_q       <= '0;
      scnt_q      <= '0;
      push_en_q   <= 1'b1;
      pop_en_q    <= 1'b1;
      rem_q       <= '0;
      size_q      <= SizeRst;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      cnt_q       <= cnt_d;
      srd_q       <= srd_d;
      swr_q       <= swr_d;
      scnt_q      <= scnt_d;
      push_en_q   <= push_en_d;
      pop_en_q    <= pop_en_d;
      rem_q       <= rem_d;
      size_q      <= size_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: command result or popped element
  always_ff @(posedge clk_i) begin
    if (pop_issue) begin
      pend_cnt_q  <= cnt_d;
      pend_free_q <= free_slots(cnt_d, size_q);
      pend_last_q <= (rem_q == REQ_W'(1));
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_value_q  <= '0;
      out_vvalid_q <= 1'b0;
      out_last_q   <= 1'b1;
      out_cnt_q    <= cnt_d;
      out_free_q   <= free_slots(cnt_d, size_q);
    end else if (pend_move) begin
      out_status_q <= ST_OK;
      out_value_q  <= VALUE_W'(rdata[VW-1:0]);
      out_vvalid_q <= 1'b1;
      out_last_q   <= pend_last_q;
      out_cnt_q    <= pend_cnt_q;
      out_free_q   <= pend_free_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_free_q, out_cnt_q, out_value_q, out_status_q};
  assign m_axis_tuser  = out_vvalid_q;
  assign m_axis_tlast  = out_last_q;

  // No element write may collide with the clearing sweep
  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !memctl.wr_en)
    else $error("element write during memory clear");

  // A popped element always carries status ok
  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (out_status_q == ST_OK))
    else $error("popped element with error status");

  // Issuing the last read of a run ends the run
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_issue && rem_q == REQ_W'(1)) |=> (state_q == S_IDLE && pend_q))
    else $error("pop run did not end after its last read");

  // The count never passes the largest size in use
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q) == S_IDLE) |-> (CMPW'(cnt_q) <= CMPW'(DEPTH)))
    else $error("element count beyond storage depth");

endmodule

@@ tb/ring_fifo_rewind_snapshot_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_rewind_snapshot_tb
// Self-checking bench for the ring FIFO with rewind and snapshot. A local
// model of pointers, count, snapshot and enables predicts every result item;
// a monitor compares each result with the oldest prediction. Directed tests
// cover the corner cases, then random command mixes run over several ring
// sizes with random gaps and stalls on both sides and one long output stall.
// ----------------------------------------------------------------------------
module ring_fifo_rewind_snapshot_tb;
  import rfrs_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEF;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int RUN_MAX     = MAX_RUN_DEF;
  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 12;
  localparam int LONG_HOLD   = 400;
  localparam int SHOW_LIMIT  = 10;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    status_e     status;
    logic [31:0] value;
    bit          valid;
    bit          last;
    logic [8:0]  stored;
    logic [8:0]  free;
  } fifo_result_t;

  // DUT ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [SIZE_W-1:0]      cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  // Model of the FIFO state
  logic [31:0] ring_mem [RING_DEPTH];
  int          rd_ptr, wr_ptr, level;
  int          snap_rd, snap_wr, snap_level;
  bit          push_en, pop_en;
  int          ring_size;

  fifo_result_t pending_results [$];

  int error_count  = 0;
  int cmds_sent    = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  bit idle_on      = 1'b1;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int stall_left   = 0;

  ring_fifo_rewind_snapshot dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Generate the clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive the result ready: long hold-off on request, else random stall bursts
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen     <= hold_seq;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_result
    fifo_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (error_count < SHOW_LIMIT)
          $display("Unexpected result item: tdata=%h tuser=%0d tlast=%0d",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.status || m_axis_tdata[34:3] !== want.value ||
            m_axis_tuser !== want.valid || m_axis_tlast !== want.last ||
            m_axis_tdata[43:35] !== want.stored || m_axis_tdata[52:44] !== want.free) begin
          if (error_count < SHOW_LIMIT) begin
            $display("Mismatch at result %0d:", results_seen);
            $display("  exp status=%0d value=%h valid=%0d last=%0d stored=%0d free=%0d",
                     want.status, want.value, want.valid, want.last, want.stored,
                     want.free);
            $display("  got status=%0d value=%h valid=%0d last=%0d stored=%0d free=%0d",
                     m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tuser, m_axis_tlast,
                     m_axis_tdata[43:35], m_axis_tdata[52:44]);
          end
          error_count++;
        end
      end
    end
  end

  function automatic int free_now();
    return (level >= ring_size) ? 0 : ring_size - level;
  endfunction

  function automatic int next_ptr(input int p);
    return (p + 1 >= ring_size) ? 0 : p + 1;
  endfunction

  function automatic void add_result(input status_e st, input logic [31:0] val,
                                     input bit valid, input bit last);
    fifo_result_t r;
    r.status = st;
    r.value  = valid ? val : 32'd0;
    r.valid  = valid;
    r.last   = last;
    r.stored = level[8:0];
    r.free   = 9'(free_now());
    pending_results.push_back(r);
  endfunction

  function automatic void clear_model();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    rd_ptr = 0; wr_ptr = 0; level = 0;
    snap_rd = 0; snap_wr = 0; snap_level = 0;
    push_en = 1'b1; pop_en = 1'b1;
    ring_size = RING_DEPTH;
  endfunction

  // Advance the model by one accepted command and queue its results
  function automatic void predict_cmd(input op_e op, input logic [31:0] val,
                                      input logic [6:0] req, input logic [8:0] amt,
                                      input bit ap, input bit apo);
    int want;
    logic [31:0] elem;
    status_e st;
    st = ST_OK;
    case (op)
      OP_PUSH: begin
        if (!push_en) st = ST_PUSH_DIS;
        else if (level >= ring_size) st = ST_FULL;
        else begin
          ring_mem[wr_ptr[RING_AW-1:0]] = val;
          wr_ptr = next_ptr(wr_ptr);
          level++;
        end
      end
      OP_POP: begin
        if (!pop_en) st = ST_POP_DIS;
        else if (level == 0) st = ST_EMPTY;
        else begin
          want = int'(req);
          if (want > RUN_MAX) want = RUN_MAX;
          if (want > level) want = level;
          if (want > 0) begin
            for (int k = 0; k < want; k++) begin
              elem = ring_mem[rd_ptr[RING_AW-1:0]];
              rd_ptr = next_ptr(rd_ptr);
              level--;
              add_result(ST_OK, elem, 1'b1, k + 1 == want);
            end
            return;
          end
        end
      end
      OP_UNREAD: begin
        if (int'(amt) > free_now()) st = ST_UNREAD_BIG;
        else begin
          level += int'(amt);
          rd_ptr = (rd_ptr >= int'(amt)) ? rd_ptr - int'(amt)
                                         : rd_ptr + ring_size - int'(amt);
          push_en = 1'b1;
        end
      end
      OP_SAVE: begin
        snap_rd = rd_ptr; snap_wr = wr_ptr; snap_level = level;
      end
      OP_RESTORE: begin
        rd_ptr = snap_rd; wr_ptr = snap_wr; level = snap_level;
      end
      OP_FLUSH: begin
        rd_ptr = 0; wr_ptr = 0; level = 0;
        push_en = 1'b1; pop_en = 1'b1;
      end
      OP_SET_EN: begin
        push_en = ap;
        pop_en  = apo;
      end
      default: ;
    endcase
    add_result(st, 32'd0, 1'b0, 1'b1);
  endfunction

  // Offer one command item, optionally after a gap, and wait for acceptance
  task automatic send_cmd(input op_e op, input logic [31:0] val, input logic [6:0] req,
                          input logic [8:0] amt, input bit ap, input bit apo);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, apo, ap, amt, req, val};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_cmd(op, val, req, amt, ap, apo);
    cmds_sent++;
  endtask

  // Command shorthands; unused fields carry random noise
  task automatic push(input logic [31:0] val);
    send_cmd(OP_PUSH, val, 7'($urandom_range(0, 64)), 9'($urandom_range(0, 256)),
             1'($urandom), 1'($urandom));
  endtask

  task automatic pop(input int n);
    send_cmd(OP_POP, $urandom, 7'(n), 9'($urandom_range(0, 256)),
             1'($urandom), 1'($urandom));
  endtask

  task automatic unread(input int n);
    send_cmd(OP_UNREAD, $urandom, 7'($urandom_range(0, 64)), 9'(n),
             1'($urandom), 1'($urandom));
  endtask

  task automatic plain(input op_e op);
    send_cmd(op, $urandom, 7'($urandom_range(0, 64)), 9'($urandom_range(0, 256)),
             1'($urandom), 1'($urandom));
  endtask

  task automatic set_en(input bit ap, input bit apo);
    send_cmd(OP_SET_EN, $urandom, 7'($urandom_range(0, 64)), 9'($urandom_range(0, 256)),
             ap, apo);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the ring size while the block is idle
  task automatic write_size(input int sz);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= SIZE_W'(sz);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ring_size = (sz < 1) ? 1 : (sz > RING_DEPTH) ? RING_DEPTH : sz;
  endtask

  // Corner cases at full size: statuses, clamps, enables, snapshot, rewind
  task automatic test_directed();
    plain(OP_RESTORE);          // restore with no snapshot taken
    pop(5);                     // empty
    push(32'h0000_0000);
    push(32'hFFFF_FFFF);
    push(32'hAAAA_AAAA);
    push(32'h5555_5555);
    pop(0);                     // zero request, no element
    plain(OP_SAVE);
    pop(RUN_MAX);               // clamped to the count
    unread(2);
    unread(255);                // more than the free space
    plain(OP_RESTORE);
    set_en(1'b0, 1'b0);
    push(32'h1234_5678);        // push disabled
    pop(1);                     // pop disabled
    unread(1);                  // allowed with pop disabled, re-enables push
    push(32'h0000_0007);
    pop(1);
    plain(OP_FLUSH);
    pop(1);
    unread(256);                // fills the whole ring from empty
    push(32'hDEAD_BEEF);        // full
    pop(RUN_MAX);
  endtask

  // Tiny rings of one and three entries: the pointers wrap often
  task automatic test_small_ring();
    write_size(1);
    plain(OP_FLUSH);
    push($urandom);
    push($urandom);
    pop(3);
    unread(1);
    unread(1);
    pop(1);
    write_size(3);
    plain(OP_FLUSH);
    for (int i = 0; i < 5; i++) push($urandom);
    pop(2);
    push($urandom);
    push($urandom);
    unread(2);
    pop(RUN_MAX);
  endtask

  // Shrink the ring below the held count, then grow it back
  task automatic test_shrink_with_data();
    write_size(RING_DEPTH);
    plain(OP_FLUSH);
    for (int i = 0; i < 10; i++) push($urandom);
    plain(OP_SAVE);
    write_size(4);
    push($urandom);
    unread(1);
    pop(3);
    pop(RUN_MAX);
    plain(OP_RESTORE);
    pop(RUN_MAX);
    write_size(RING_DEPTH);
    plain(OP_FLUSH);
  endtask

  // Hold the output off for a long stretch while commands keep coming
  task automatic test_output_hold();
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 10; i++) push($urandom);
    pop(RUN_MAX);
    for (int i = 0; i < 10; i++) push($urandom);
    pop(RUN_MAX);
    pop(RUN_MAX);
  endtask

  // Random mix of commands, weighted toward pushes and pops
  task automatic test_random_mix(input int n_items);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) push($urandom);
      else if (pick < 65) pop(($urandom_range(0, 9) == 0) ? RUN_MAX : $urandom_range(0, 8));
      else if (pick < 73) begin
        if ($urandom_range(0, 2) == 0) unread($urandom_range(0, 256));
        else unread($urandom_range(0, free_now() > 8 ? 8 : free_now()));
      end
      else if (pick < 79) plain(OP_SAVE);
      else if (pick < 85) plain(OP_RESTORE);
      else if (pick < 88) plain(OP_FLUSH);
      else set_en($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    clear_model();
    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_small_ring();
    test_shrink_with_data();
    test_output_hold();

    write_size(RING_DEPTH);
    test_random_mix(40);
    write_size($urandom_range(2, 40));
    test_random_mix(40);
    write_size(1);
    test_random_mix(30);
    write_size($urandom_range(1, RING_DEPTH));
    idle_on <= 1'b0;
    test_random_mix(40);

    drain_results();
    repeat (10) @(posedge clk_i);
    error_count += pending_results.size();

    $display("Ran %0d commands and checked %0d result items", cmds_sent, results_seen);
    $display("Sizes 1 to %0d, shrink with data, rewind, snapshots, enables, long stall",
             RING_DEPTH);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
